FILE: rtl/bsalu_pkg.sv
// shared types and operation codes for the barrel shifter alu with flags
package bsalu_pkg;

  localparam int unsigned DataWidth = 32;

  typedef enum logic [3:0] {
    OP_AND = 4'h0,
    OP_EOR = 4'h1,
    OP_SUB = 4'h2,
    OP_RSB = 4'h3,
    OP_ADD = 4'h4,
    OP_ADC = 4'h5,
    OP_SBC = 4'h6,
    OP_RSC = 4'h7,
    OP_TST = 4'h8,
    OP_TEQ = 4'h9,
    OP_CMP = 4'hA,
    OP_CMN = 4'hB,
    OP_ORR = 4'hC,
    OP_MOV = 4'hD,
    OP_BIC = 4'hE,
    OP_MVN = 4'hF
  } alu_op_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_kind_e;

  typedef struct packed {
    logic [3:0]           command;
    logic [DataWidth-1:0] first_operand;
    logic [DataWidth-1:0] second_operand;
    logic [1:0]           shift_kind;
    logic [4:0]           shift_amount;
    logic                 set_flags;
    logic                 flag_n_in;
    logic                 flag_z_in;
    logic                 flag_c_in;
    logic                 flag_v_in;
  } bsalu_in_t;

  typedef struct packed {
    logic [DataWidth-1:0] result;
    logic                 writes_result;
    logic                 flag_n;
    logic                 flag_z;
    logic                 flag_c;
    logic                 flag_v;
  } bsalu_out_t;

  typedef struct packed {
    logic [DataWidth-1:0] value;
    logic                 carry;
  } shift_res_t;

endpackage

FILE: rtl/barrel_shift_alu_flags_top.sv
// top level: registered barrel shifter and alu with nzcv flag update
// a transaction is registered in the input stage when accepted, then in the result stage, and is taken from rsp_o
// throughput: one transaction per cycle, busy_o is never raised
// the path between the input and result registers is one shift plus one 33-bit add
// the result is shown for one cycle with done_o high; the receiver cannot stall
// reset clears the valid bits of both register stages, payload registers are not reset
module barrel_shift_alu_flags_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  bsalu_pkg::bsalu_in_t  req_i,
  output logic                  busy_o,
  output logic                  done_o,
  output bsalu_pkg::bsalu_out_t rsp_o
);
  import bsalu_pkg::*;

  // input stage
  logic       valid_q;
  logic       valid_d;
  bsalu_in_t  req_q;

  // result stage
  logic       done_q;
  logic       done_d;
  bsalu_out_t rsp_q;
  bsalu_out_t rsp_d;

  shift_res_t shift_res;
  logic       accept;

  // a new transaction can enter every cycle, so there is never back-pressure
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign valid_d = accept;
  assign done_d  = valid_q;

  // control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

  // payload registers, loaded only when their stage takes a transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  // second operand through the immediate shifter
  bsalu_shifter u_shifter (
    .value_i  (req_q.second_operand),
    .kind_i   (req_q.shift_kind),
    .amount_i (req_q.shift_amount),
    .carry_i  (req_q.flag_c_in),
    .res_o    (shift_res)
  );

  // alu operation and flag selection
  bsalu_alu u_alu (
    .req_i   (req_q),
    .shift_i (shift_res),
    .rsp_o   (rsp_d)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  // every accepted transaction comes out at done_o after passing the input and result stages
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("accepted transaction did not complete in two cycles");

  // no result strobe without a transaction accepted ahead of it through the input and result stages
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result strobe without an accepted transaction");

  // compare operations never write the destination
  a_compare_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (req_q.command == OP_TST || req_q.command == OP_TEQ ||
                 req_q.command == OP_CMP || req_q.command == OP_CMN))
    |=> !rsp_o.writes_result)
    else $error("compare operation flagged as writing a result");

  // without set_flags the incoming flags pass unchanged
  a_flags_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !req_q.set_flags) |=>
      (rsp_o.flag_n == $past(req_q.flag_n_in) && rsp_o.flag_z == $past(req_q.flag_z_in) &&
       rsp_o.flag_c == $past(req_q.flag_c_in) && rsp_o.flag_v == $past(req_q.flag_v_in)))
    else $error("flags changed without set_flags");

  // logical operations leave the overflow flag alone
  a_logic_keeps_v : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (req_q.command == OP_AND || req_q.command == OP_EOR ||
                 req_q.command == OP_TST || req_q.command == OP_TEQ ||
                 req_q.command == OP_ORR || req_q.command == OP_MOV ||
                 req_q.command == OP_BIC || req_q.command == OP_MVN))
    |=> rsp_o.flag_v == $past(req_q.flag_v_in))
    else $error("logical operation changed the overflow flag");
`endif

endmodule

FILE: rtl/bsalu_shifter.sv
// immediate barrel shifter with shifter carry out
module bsalu_shifter (
  input  logic [bsalu_pkg::DataWidth-1:0] value_i,
  input  logic [1:0]                      kind_i,
  input  logic [4:0]                      amount_i,
  input  logic                            carry_i,
  output bsalu_pkg::shift_res_t           res_o
);
  import bsalu_pkg::*;

  logic [DataWidth:0]          lsl_ext;
  logic [DataWidth:0]          lsr_ext;
  logic signed [DataWidth:0]   asr_ext;
  logic [2*DataWidth-1:0]      ror_ext;

  // one extra bit catches the last bit shifted out
  assign lsl_ext = {1'b0, value_i} << amount_i;
  assign lsr_ext = {value_i, 1'b0} >> amount_i;
  assign asr_ext = $signed({value_i, 1'b0}) >>> amount_i;
  assign ror_ext = {value_i, value_i} >> amount_i;

  always_comb begin
    res_o.value = value_i;
    res_o.carry = carry_i;
    case (shift_kind_e'(kind_i))
      SH_LSL: begin
        if (amount_i != 5'd0) begin
          res_o.value = lsl_ext[DataWidth-1:0];
          res_o.carry = lsl_ext[DataWidth];
        end
      end
      SH_LSR: begin
        // zero amount means shift by 32
        if (amount_i == 5'd0) begin
          res_o.value = '0;
          res_o.carry = value_i[DataWidth-1];
        end else begin
          res_o.value = lsr_ext[DataWidth:1];
          res_o.carry = lsr_ext[0];
        end
      end
      SH_ASR: begin
        if (amount_i == 5'd0) begin
          res_o.value = {DataWidth{value_i[DataWidth-1]}};
          res_o.carry = value_i[DataWidth-1];
        end else begin
          res_o.value = asr_ext[DataWidth:1];
          res_o.carry = asr_ext[0];
        end
      end
      default: begin
        // zero amount is rrx: rotate through carry by one
        if (amount_i == 5'd0) begin
          res_o.value = {carry_i, value_i[DataWidth-1:1]};
          res_o.carry = value_i[0];
        end else begin
          res_o.value = ror_ext[DataWidth-1:0];
          res_o.carry = ror_ext[DataWidth-1];
        end
      end
    endcase
  end

endmodule

FILE: rtl/bsalu_alu.sv
// sixteen data-processing operations and nzcv flag update
module bsalu_alu (
  input  bsalu_pkg::bsalu_in_t  req_i,
  input  bsalu_pkg::shift_res_t shift_i,
  output bsalu_pkg::bsalu_out_t rsp_o
);
  import bsalu_pkg::*;

  alu_op_e              op;
  logic [DataWidth-1:0] rn;
  logic [DataWidth-1:0] rm;
  logic [DataWidth-1:0] add_a;
  logic [DataWidth-1:0] add_b;
  logic                 add_ci;
  logic [DataWidth:0]   sum;
  logic [DataWidth-1:0] logic_res;
  logic [DataWidth-1:0] res;
  logic                 arith;
  logic                 add_v;

  assign op = alu_op_e'(req_i.command);
  assign rn = req_i.first_operand;
  assign rm = shift_i.value;

  always_comb begin
    add_a     = rn;
    add_b     = ~rm;
    add_ci    = 1'b1;
    arith     = 1'b0;
    logic_res = '0;
    unique case (op)
      OP_AND, OP_TST: logic_res = rn & rm;
      OP_EOR, OP_TEQ: logic_res = rn ^ rm;
      OP_SUB, OP_CMP: arith = 1'b1;
      OP_RSB: begin
        add_a = rm;
        add_b = ~rn;
        arith = 1'b1;
      end
      OP_ADD, OP_CMN: begin
        add_b  = rm;
        add_ci = 1'b0;
        arith  = 1'b1;
      end
      OP_ADC: begin
        add_b  = rm;
        add_ci = req_i.flag_c_in;
        arith  = 1'b1;
      end
      OP_SBC: begin
        add_ci = req_i.flag_c_in;
        arith  = 1'b1;
      end
      OP_RSC: begin
        add_a  = rm;
        add_b  = ~rn;
        add_ci = req_i.flag_c_in;
        arith  = 1'b1;
      end
      OP_ORR: logic_res = rn | rm;
      OP_MOV: logic_res = rm;
      OP_BIC: logic_res = rn & ~rm;
      OP_MVN: logic_res = ~rm;
    endcase
  end

  assign sum   = {1'b0, add_a} + {1'b0, add_b} + {{DataWidth{1'b0}}, add_ci};
  assign res   = arith ? sum[DataWidth-1:0] : logic_res;
  assign add_v = ~(add_a[DataWidth-1] ^ add_b[DataWidth-1])
               & (add_a[DataWidth-1] ^ sum[DataWidth-1]);

  always_comb begin
    rsp_o.result        = res;
    rsp_o.writes_result = !(op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
    rsp_o.flag_n        = req_i.flag_n_in;
    rsp_o.flag_z        = req_i.flag_z_in;
    rsp_o.flag_c        = req_i.flag_c_in;
    rsp_o.flag_v        = req_i.flag_v_in;
    if (req_i.set_flags) begin
      rsp_o.flag_n = res[DataWidth-1];
      rsp_o.flag_z = (res == '0);
      rsp_o.flag_c = arith ? sum[DataWidth] : shift_i.carry;
      if (arith) begin
        rsp_o.flag_v = add_v;
      end
    end
  end

endmodule
